### rtl/irtm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 range table match block.
// No dependencies; irtm_if, irtm_best and ip_range_table_match import this package.
package irtm_pkg;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned SLOT_W  = 7;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned ENTRY_W = 2 * IP_W;

  // cmd field codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } irtm_state_t;

  // sequencer to best-match tracker
  typedef struct packed {
    logic clear;
    logic sample;
  } best_ctl_t;

endpackage

### rtl/irtm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the range table: command input and result output.
// Depends on irtm_pkg for the field widths.
interface irtm_in_if
  import irtm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SLOT_W-1:0] entry_index;
  logic [IP_W-1:0]   range_low;
  logic [IP_W-1:0]   range_high;
  logic [IP_W-1:0]   address;

  modport source (output valid, cmd, entry_index, range_low, range_high, address,
                  input ready);
  modport sink   (input valid, cmd, entry_index, range_low, range_high, address,
                  output ready);
endinterface

interface irtm_out_if
  import irtm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] match_index;
  logic [IP_W-1:0]   match_low;
  logic [IP_W-1:0]   match_high;

  modport source (output valid, hit, match_index, match_low, match_high,
                  input ready);
  modport sink   (input valid, hit, match_index, match_low, match_high,
                  output ready);
endinterface

### rtl/irtm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module irtm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/irtm_best.sv
`timescale 1ns / 1ps
// Best-match tracker: tests each entry read from the table against the query address
// and keeps the containing entry with the greatest low bound. Depends on irtm_pkg.
module irtm_best
  import irtm_pkg::*;
#(
  parameter int unsigned IDX_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  best_ctl_t        ctl,
  input  logic [IP_W-1:0]  addr,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic [IP_W-1:0]  rd_low,
  input  logic [IP_W-1:0]  rd_high,
  output logic             found,
  output logic [IDX_W-1:0] best_idx,
  output logic [IP_W-1:0]  best_low,
  output logic [IP_W-1:0]  best_high
);

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IP_W-1:0]  low_r, high_r;
  logic             take;

  // strict greater keeps the lowest slot on ties, since slots arrive in order
  assign take = ctl.sample && (rd_low <= addr) && (addr <= rd_high) &&
                (!found_r || (rd_low > low_r));

  always_comb begin
    found_nxt = found_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      idx_r  <= rd_idx;
      low_r  <= rd_low;
      high_r <= rd_high;
    end
  end

  assign found     = found_r;
  assign best_idx  = idx_r;
  assign best_low  = low_r;
  assign best_high = high_r;

endmodule

### rtl/ip_range_table_match.sv
`timescale 1ns / 1ps
// Top level of the IPv4 range table match block: sequencer, table RAM, result register.
// Depends on irtm_pkg, irtm_if, irtm_ram and irtm_best.

// A write transfer (cmd 0) stores {range_low, range_high} into slot entry_index and
// gives no result; writes to slots at or above TABLE_DEPTH are dropped. A query
// transfer (cmd 1) scans slots 0 to entry_count-1 (entry_count saturated at
// TABLE_DEPTH) through one read port of the table RAM, one slot per cycle, and returns
// one result: hit, plus the index and bounds of the containing range with the greatest
// low bound (lowest slot on ties), all zero on a miss. The result sits in an output
// register, so the next transfer is taken while a result waits; only the end of a scan
// holds until the output register is free. Slots never written read back undefined.
// The user must write entry_count through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this.
module ip_range_table_match
  import irtm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  irtm_in_if.sink            in_ch,
  irtm_out_if.source         out_ch
);

  // slot index width, count width (holds TABLE_DEPTH), and a compare width wide enough
  // for both the 7-bit slot field and the 8-bit count register
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  irtm_state_t        state_r, state_nxt;
  logic [COUNT_W-1:0] entry_count_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [IDX_W-1:0]   data_idx_r;
  logic               data_vld_r;
  logic [IP_W-1:0]    addr_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [SLOT_W-1:0]  out_idx_r;
  logic [IP_W-1:0]    out_low_r, out_high_r;

  // handshake and decode
  logic               in_xfer, query_xfer, ram_we;
  logic               scan_rd, last_rd, out_load;
  best_ctl_t          best_ctl;
  logic [SW-1:0]      slot_ext, count_ext;
  logic [CNT_W-1:0]   count_sat;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [SW-1:0]      best_idx_ext;
  logic [IP_W-1:0]    best_low, best_high;

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign query_xfer = in_xfer && (in_ch.cmd == CMD_QUERY);

  assign slot_ext = SW'(in_ch.entry_index);
  assign ram_we   = in_xfer && (in_ch.cmd == CMD_WRITE) && (slot_ext < SW'(TABLE_DEPTH));

  // saturate the configured count to the table depth
  assign count_ext = SW'(entry_count_r);
  assign count_sat = (count_ext > SW'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                    : CNT_W'(count_ext);

  assign last_rd = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (query_xfer) begin
          state_nxt = (count_sat == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_rd) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready     = 1'b0;
    scan_rd         = 1'b0;
    out_load        = 1'b0;
    best_ctl.clear  = query_xfer;
    best_ctl.sample = data_vld_r;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_SCAN:  scan_rd     = 1'b1;
      ST_DRAIN: scan_rd     = 1'b0;
      ST_EMIT:  out_load    = !out_valid_r || out_ch.ready;
      default:  in_ch.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      data_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      data_vld_r <= scan_rd;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan counters and query address
  always_ff @(posedge clk) begin
    if (query_xfer) begin
      addr_r   <= in_ch.address;
      cnt_r    <= count_sat;
      rd_idx_r <= '0;
    end else if (scan_rd) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
    data_idx_r <= rd_idx_r;
  end

  // table: {low, high} per slot
  irtm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_ext[IDX_W-1:0]),
    .wdata ({in_ch.range_low, in_ch.range_high}),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  irtm_best #(
    .IDX_W (IDX_W)
  ) u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (best_ctl),
    .addr      (addr_r),
    .rd_idx    (data_idx_r),
    .rd_low    (ram_rdata[ENTRY_W-1:IP_W]),
    .rd_high   (ram_rdata[IP_W-1:0]),
    .found     (found),
    .best_idx  (best_idx),
    .best_low  (best_low),
    .best_high (best_high)
  );

  // result register; fields forced to zero on a miss
  assign best_idx_ext = SW'(best_idx);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r  <= found;
      out_idx_r  <= found ? best_idx_ext[SLOT_W-1:0] : '0;
      out_low_r  <= found ? best_low  : '0;
      out_high_r <= found ? best_high : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.match_index = out_idx_r;
  assign out_ch.match_low   = out_low_r;
  assign out_ch.match_high  = out_high_r;

`ifndef SYNTHESIS
  // reads never go past the in-use slots
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(rd_idx_r) < cnt_r))
    else $error("scan read index beyond entry count");

  // a reported hit really contains the queried address
  a_hit_contains: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (!out_hit_r || ((out_low_r <= addr_r) && (addr_r <= out_high_r))))
    else $error("hit result does not contain the query address");

  // an empty table never hits
  a_empty_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (cnt_r == '0)) |=> !out_hit_r)
    else $error("hit reported with no entries in use");
`endif

endmodule
